### hdl/thws_pkg.sv
// Shared types, widths and codes for the triangle Haar wavelet step core.
// Used by thws_front, thws_back and the top level; depends on nothing.
package thws_pkg;

    localparam int VAL_W  = 32;
    localparam int AREA_W = 32;
    localparam int PROD_W = VAL_W + AREA_W + 1;
    localparam int SUM_W  = PROD_W + 3;
    localparam int MAG_W  = SUM_W - 1;
    localparam int DIV_W  = AREA_W + 2;
    localparam int DD_W   = DIV_W + 1;
    localparam int NUM_W  = SUM_W;
    localparam int Q_W    = 34;
    localparam int LO_W   = NUM_W - Q_W;
    localparam int HI_W   = NUM_W - Q_W;
    localparam int SAT_W  = 37;

    localparam logic       CMD_ANALYSIS  = 1'b0;
    localparam logic       CMD_SYNTHESIS = 1'b1;
    localparam logic [3:0] FLAGS_ALL     = 4'hF;
    localparam logic [3:0] FLAGS_NONE    = 4'h0;

    typedef enum logic [1:0] {
        MODE_SKIP,
        MODE_ANALYSIS,
        MODE_SYNTHESIS
    } mode_t;

    typedef struct packed {
        logic                          command;
        logic                          present;
        logic [3:0]                    flags;
        logic [3:0][VAL_W-1:0]         value;
        logic [3:0][AREA_W-1:0]        area;
    } in_item_t;

    typedef struct packed {
        mode_t                         mode;
        logic [3:0]                    flags;
        logic [3:0][VAL_W-1:0]         value;
        logic [3:0][PROD_W-1:0]        prod;
        logic [DIV_W-1:0]              divisor;
    } front_item_t;

    typedef struct packed {
        logic                          applied;
        logic [3:0][VAL_W-1:0]         value;
        logic [3:0]                    flags;
        logic                          parent_write;
    } out_item_t;

    function automatic logic [VAL_W-1:0] sat32(input logic signed [SAT_W-1:0] x);
        logic [VAL_W-1:0] r;
        if (x > $signed(SAT_W'(32'h7FFF_FFFF)))
            r = 32'h7FFF_FFFF;
        else if (x < -$signed(SAT_W'(33'h1_0000_0000) >>> 1))
            r = 32'h8000_0000;
        else
            r = x[VAL_W-1:0];
        return r;
    endfunction

endpackage

### hdl/triangle_haar_wavelet_step_core.sv
// Top level of the triangle Haar wavelet step core.
// Depends on thws_pkg, thws_front, thws_fifo and thws_back.
//
// Usage:
//   Input side is a queue: drive the node word on the input ports and raise
//   push; the word is taken at a clock edge where push is high and full low.
//   Result side is a queue: while empty is low the oldest result sits on the
//   result ports; it is taken at a clock edge where pop is high.
//   Throughput: one node word per cycle, sustained, with pop held high.
//   Path: a taken word passes 2 front stages, the front/back queue, 3 sum
//   stages, a 35-stage divider (a setup stage, then one quotient bit per
//   stage), 2 saturation stages, the result buffer. The divider pipeline
//   sets the latency; one word enters it each cycle unless the back holds.
//   Reset clears both queues and all stage valid bits; no configuration.
//   When the receiver stops popping, the back part holds once the result
//   buffer fills, the front/back queue then fills, and full rises; no word
//   is lost or repeated.
module triangle_haar_wavelet_step_core #(
    parameter int QUEUE_DEPTH = 4,
    parameter int OUT_DEPTH   = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        command,
    input  logic        children_present,
    input  logic [3:0]  child_flags,
    input  logic signed [31:0] value_zero,
    input  logic signed [31:0] value_one,
    input  logic signed [31:0] value_two,
    input  logic signed [31:0] value_three,
    input  logic [31:0] area_zero,
    input  logic [31:0] area_one,
    input  logic [31:0] area_two,
    input  logic [31:0] area_three,
    output logic        empty,
    input  logic        pop,
    output logic        applied,
    output logic signed [31:0] out_zero,
    output logic signed [31:0] out_one,
    output logic signed [31:0] out_two,
    output logic signed [31:0] out_three,
    output logic [3:0]  out_flags,
    output logic        parent_write
);

    thws_pkg::in_item_t    in_item;
    thws_pkg::front_item_t f_item;
    thws_pkg::front_item_t q_rdata;
    thws_pkg::out_item_t   b_item;
    thws_pkg::out_item_t   o_rdata;
    logic                  accept;
    logic                  f_push;
    logic                  q_full;
    logic                  q_empty;
    logic                  q_pop;
    logic                  o_push;
    logic                  o_full;

    assign full   = q_full;
    assign accept = push && !q_full;

    assign in_item.command  = command;
    assign in_item.present  = children_present;
    assign in_item.flags    = child_flags;
    assign in_item.value[0] = value_zero;
    assign in_item.value[1] = value_one;
    assign in_item.value[2] = value_two;
    assign in_item.value[3] = value_three;
    assign in_item.area[0]  = area_zero;
    assign in_item.area[1]  = area_one;
    assign in_item.area[2]  = area_two;
    assign in_item.area[3]  = area_three;

    thws_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .in_item  (in_item),
        .q_full   (q_full),
        .q_push   (f_push),
        .q_item   (f_item)
    );

    thws_fifo #(
        .WIDTH ($bits(thws_pkg::front_item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_push),
        .wdata (f_item),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty),
        .full  (q_full)
    );

    thws_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_item   (q_rdata),
        .q_pop    (q_pop),
        .out_full (o_full),
        .o_push   (o_push),
        .o_item   (b_item)
    );

    thws_fifo #(
        .WIDTH ($bits(thws_pkg::out_item_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (o_push),
        .wdata (b_item),
        .pop   (pop),
        .rdata (o_rdata),
        .empty (empty),
        .full  (o_full)
    );

    assign applied      = o_rdata.applied;
    assign out_zero     = o_rdata.value[0];
    assign out_one      = o_rdata.value[1];
    assign out_two      = o_rdata.value[2];
    assign out_three    = o_rdata.value[3];
    assign out_flags    = o_rdata.flags;
    assign parent_write = o_rdata.parent_write;

endmodule

### hdl/thws_fifo.sv
// Small register-based first-in first-out queue with a flat data word.
// Generic; used between front and back and as the result buffer.
module thws_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty,
    output logic             full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wptr_reg;
    logic [AW-1:0]    rptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
                wptr_reg <= (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            if (do_pop)
                rptr_reg <= (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wptr_reg] <= wdata;
    end

endmodule

### hdl/thws_front.sv
// Front part: registers each node word, classifies the step and forms the
// area-weighted products and the divisor. Depends on thws_pkg.
module thws_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  thws_pkg::in_item_t    in_item,
    input  logic                  q_full,
    output logic                  q_push,
    output thws_pkg::front_item_t q_item
);

    logic                  adv;
    logic                  s1_valid_reg;
    thws_pkg::in_item_t    s1_item_reg;
    thws_pkg::mode_t       s1_mode_reg;
    thws_pkg::mode_t       mode_next;
    logic                  s2_valid_reg;
    thws_pkg::front_item_t s2_item_reg;
    thws_pkg::front_item_t s2_next;
    logic signed [thws_pkg::PROD_W-1:0] prod [4];

    assign adv    = !q_full;
    assign q_push = s2_valid_reg && adv;
    assign q_item = s2_item_reg;

    always_comb
    begin
        mode_next = thws_pkg::MODE_SKIP;
        if (in_item.present && (in_item.area[0] != '0))
        begin
            if (in_item.command == thws_pkg::CMD_ANALYSIS && in_item.flags != thws_pkg::FLAGS_ALL)
                mode_next = thws_pkg::MODE_ANALYSIS;
            else if (in_item.command == thws_pkg::CMD_SYNTHESIS
                     && in_item.flags == thws_pkg::FLAGS_ALL)
                mode_next = thws_pkg::MODE_SYNTHESIS;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            prod[i] = $signed({1'b0, s1_item_reg.area[i]}) * $signed(s1_item_reg.value[i]);
        s2_next.mode  = s1_mode_reg;
        s2_next.flags = s1_item_reg.flags;
        s2_next.value = s1_item_reg.value;
        for (int i = 0; i < 4; i++)
            s2_next.prod[i] = prod[i];
        if (s1_mode_reg == thws_pkg::MODE_SYNTHESIS)
        begin
            s2_next.prod[0] = '0;
            s2_next.divisor = thws_pkg::DIV_W'(s1_item_reg.area[0]);
        end
        else
        begin
            s2_next.divisor = thws_pkg::DIV_W'(s1_item_reg.area[0])
                            + thws_pkg::DIV_W'(s1_item_reg.area[1])
                            + thws_pkg::DIV_W'(s1_item_reg.area[2])
                            + thws_pkg::DIV_W'(s1_item_reg.area[3]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_item_reg <= in_item;
            s1_mode_reg <= mode_next;
            s2_item_reg <= s2_next;
        end
    end

endmodule

### hdl/thws_back.sv
// Back part: sums the products, runs a one-bit-per-stage rounding divider
// and saturates the new child values. Depends on thws_pkg.
module thws_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_empty,
    input  thws_pkg::front_item_t q_item,
    output logic                  q_pop,
    input  logic                  out_full,
    output logic                  o_push,
    output thws_pkg::out_item_t   o_item
);

    localparam int SUM_W = thws_pkg::SUM_W;
    localparam int Q_W   = thws_pkg::Q_W;
    localparam int DD_W  = thws_pkg::DD_W;
    localparam int LO_W  = thws_pkg::LO_W;
    localparam int HI_W  = thws_pkg::HI_W;
    localparam int VAL_W = thws_pkg::VAL_W;
    localparam int SAT_W = thws_pkg::SAT_W;

    typedef struct packed {
        thws_pkg::mode_t               mode;
        logic [3:0]                    flags;
        logic [3:0][VAL_W-1:0]         value;
    } base_t;

    typedef struct packed {
        base_t                         base;
        logic [thws_pkg::DIV_W-1:0]    divisor;
        logic [SUM_W-1:0]              sum;
    } sum_t;

    typedef struct packed {
        base_t                         base;
        logic [thws_pkg::DIV_W-1:0]    divisor;
        logic                          neg;
        logic [thws_pkg::MAG_W-1:0]    mag;
    } mag_t;

    typedef struct packed {
        base_t                         base;
        logic [DD_W-1:0]               dd;
        logic                          neg;
        logic [thws_pkg::NUM_W-1:0]    num;
    } num_t;

    typedef struct packed {
        base_t                         base;
        logic                          neg;
        logic                          ovf;
        logic [DD_W-1:0]               dd;
        logic [DD_W-1:0]               rem;
        logic [LO_W-1:0]               nlo;
        logic [Q_W-1:0]                quo;
    } div_t;

    typedef struct packed {
        base_t                         base;
        logic [3:0][VAL_W-1:0]         res;
    } fin_t;

    logic          adv;
    logic          b1_valid_reg;
    logic          b2_valid_reg;
    logic          b3_valid_reg;
    logic          e1_valid_reg;
    logic          e2_valid_reg;
    logic          div_valid_reg [Q_W+1];
    sum_t          b1_reg;
    sum_t          b1_next;
    mag_t          b2_reg;
    mag_t          b2_next;
    num_t          b3_reg;
    num_t          b3_next;
    div_t          div_reg  [Q_W+1];
    div_t          div_next [Q_W+1];
    fin_t          e1_reg;
    fin_t          e1_next;
    thws_pkg::out_item_t e2_reg;
    thws_pkg::out_item_t e2_next;

    logic [DD_W:0]              r2   [Q_W+1];
    logic [DD_W:0]              diff [Q_W+1];
    logic                       ge   [Q_W+1];
    logic [Q_W-1:0]             qc;
    logic signed [Q_W:0]        t;
    logic signed [VAL_W:0]      hdiff [4];
    logic signed [VAL_W+1:0]    hsum  [4];

    assign adv    = !out_full;
    assign q_pop  = adv && !q_empty;
    assign o_push = e2_valid_reg && adv;
    assign o_item = e2_reg;

    always_comb
    begin
        b1_next.base.mode  = q_item.mode;
        b1_next.base.flags = q_item.flags;
        b1_next.base.value = q_item.value;
        b1_next.divisor    = q_item.divisor;
        b1_next.sum = {{(SUM_W-thws_pkg::PROD_W){q_item.prod[0][thws_pkg::PROD_W-1]}}, q_item.prod[0]}
                    + {{(SUM_W-thws_pkg::PROD_W){q_item.prod[1][thws_pkg::PROD_W-1]}}, q_item.prod[1]}
                    + {{(SUM_W-thws_pkg::PROD_W){q_item.prod[2][thws_pkg::PROD_W-1]}}, q_item.prod[2]}
                    + {{(SUM_W-thws_pkg::PROD_W){q_item.prod[3][thws_pkg::PROD_W-1]}}, q_item.prod[3]};
        if (q_item.mode == thws_pkg::MODE_SYNTHESIS)
            b1_next.sum = {b1_next.sum[SUM_W-2:0], 1'b0};
    end

    always_comb
    begin
        b2_next.base    = b1_reg.base;
        b2_next.divisor = b1_reg.divisor;
        b2_next.neg     = b1_reg.sum[SUM_W-1];
        b2_next.mag     = b1_reg.sum[SUM_W-1] ? thws_pkg::MAG_W'(-b1_reg.sum)
                                              : b1_reg.sum[thws_pkg::MAG_W-1:0];
    end

    always_comb
    begin
        b3_next.base = b2_reg.base;
        b3_next.neg  = b2_reg.neg;
        b3_next.dd   = {b2_reg.divisor, 1'b0};
        b3_next.num  = {b2_reg.mag, 1'b0} + thws_pkg::NUM_W'(b2_reg.divisor);
    end

    always_comb
    begin
        div_next[0].base = b3_reg.base;
        div_next[0].neg  = b3_reg.neg;
        div_next[0].dd   = b3_reg.dd;
        div_next[0].rem  = DD_W'(b3_reg.num[thws_pkg::NUM_W-1:LO_W]);
        div_next[0].ovf  = DD_W'(b3_reg.num[thws_pkg::NUM_W-1:LO_W]) >= b3_reg.dd;
        div_next[0].nlo  = b3_reg.num[LO_W-1:0];
        div_next[0].quo  = '0;
        r2[0]   = '0;
        diff[0] = '0;
        ge[0]   = 1'b0;
        for (int k = 1; k <= Q_W; k++)
        begin
            r2[k]   = {div_reg[k-1].rem, div_reg[k-1].nlo[LO_W-1]};
            diff[k] = r2[k] - {1'b0, div_reg[k-1].dd};
            ge[k]   = r2[k] >= {1'b0, div_reg[k-1].dd};
            div_next[k]     = div_reg[k-1];
            div_next[k].rem = ge[k] ? diff[k][DD_W-1:0] : r2[k][DD_W-1:0];
            div_next[k].nlo = {div_reg[k-1].nlo[LO_W-2:0], 1'b0};
            div_next[k].quo = {div_reg[k-1].quo[Q_W-2:0], ge[k]};
        end
    end

    always_comb
    begin
        if (div_reg[Q_W].ovf || div_reg[Q_W].quo[Q_W-1])
            qc = {1'b1, {(Q_W-1){1'b0}}};
        else
            qc = div_reg[Q_W].quo;
        t = div_reg[Q_W].neg ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
        e1_next.base = div_reg[Q_W].base;
        e1_next.res  = div_reg[Q_W].base.value;
        unique case (div_reg[Q_W].base.mode)
            thws_pkg::MODE_ANALYSIS:
            begin
                e1_next.res[0] = thws_pkg::sat32(SAT_W'(t));
            end
            thws_pkg::MODE_SYNTHESIS:
            begin
                e1_next.res[0] = thws_pkg::sat32(
                    SAT_W'($signed(div_reg[Q_W].base.value[0])) - SAT_W'(t));
                for (int i = 1; i < 4; i++)
                    e1_next.res[i] = thws_pkg::sat32(
                        SAT_W'($signed(div_reg[Q_W].base.value[0]))
                        + (SAT_W'($signed(div_reg[Q_W].base.value[i])) <<< 1));
            end
            default:
            begin
                e1_next.res = div_reg[Q_W].base.value;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            hdiff[i] = $signed({e1_reg.base.value[i][VAL_W-1], e1_reg.base.value[i]})
                     - $signed({e1_reg.res[0][VAL_W-1], e1_reg.res[0]});
            hsum[i]  = $signed({hdiff[i][VAL_W], hdiff[i]})
                     + $signed({{(VAL_W+1){1'b0}}, !hdiff[i][VAL_W]});
        end
        e2_next.value        = e1_reg.res;
        e2_next.flags        = e1_reg.base.flags;
        e2_next.applied      = 1'b0;
        e2_next.parent_write = 1'b0;
        unique case (e1_reg.base.mode)
            thws_pkg::MODE_ANALYSIS:
            begin
                for (int i = 1; i < 4; i++)
                    e2_next.value[i] = thws_pkg::sat32(SAT_W'(hsum[i] >>> 1));
                e2_next.flags        = thws_pkg::FLAGS_ALL;
                e2_next.applied      = 1'b1;
                e2_next.parent_write = 1'b1;
            end
            thws_pkg::MODE_SYNTHESIS:
            begin
                e2_next.flags   = thws_pkg::FLAGS_NONE;
                e2_next.applied = 1'b1;
            end
            default:
            begin
                e2_next.value = e1_reg.base.value;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
            e1_valid_reg <= 1'b0;
            e2_valid_reg <= 1'b0;
            for (int k = 0; k <= Q_W; k++)
                div_valid_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            b1_valid_reg     <= q_pop;
            b2_valid_reg     <= b1_valid_reg;
            b3_valid_reg     <= b2_valid_reg;
            div_valid_reg[0] <= b3_valid_reg;
            for (int k = 1; k <= Q_W; k++)
                div_valid_reg[k] <= div_valid_reg[k-1];
            e1_valid_reg     <= div_valid_reg[Q_W];
            e2_valid_reg     <= e1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b1_reg <= b1_next;
            b2_reg <= b2_next;
            b3_reg <= b3_next;
            for (int k = 0; k <= Q_W; k++)
                div_reg[k] <= div_next[k];
            e1_reg <= e1_next;
            e2_reg <= e2_next;
        end
    end

endmodule

### sim/triangle_haar_wavelet_step_core_tb.sv
// Self-checking testbench for triangle_haar_wavelet_step_core: directed table, then random words.
// Depends on thws_pkg and the core; results checked vs typed rows or an in-bench Haar step predictor.
module triangle_haar_wavelet_step_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM  = 1850;
    localparam int CYC_LIMIT = 600000;
    localparam logic [127:0] Q_CAP = 128'd1 << 40;

    typedef struct {
        thws_pkg::in_item_t  word;
        bit                  typed;
        thws_pkg::out_item_t result;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    thws_pkg::in_item_t cur = '0;
    logic full, empty, applied, parent_write;
    logic signed [31:0] out_zero, out_one, out_two, out_three;
    logic [3:0] out_flags;

    row_t                dir_rows[$];
    thws_pkg::out_item_t expected_q[$];
    int                  errors = 0;
    int                  cycles = 0;
    bit                  pending_typed = 1'b0;
    thws_pkg::out_item_t pending_result;

    triangle_haar_wavelet_step_core u_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .command(cur.command), .children_present(cur.present), .child_flags(cur.flags),
        .value_zero(cur.value[0]), .value_one(cur.value[1]),
        .value_two(cur.value[2]), .value_three(cur.value[3]),
        .area_zero(cur.area[0]), .area_one(cur.area[1]),
        .area_two(cur.area[2]), .area_three(cur.area[3]),
        .empty(empty), .pop(pop), .applied(applied),
        .out_zero(out_zero), .out_one(out_one), .out_two(out_two), .out_three(out_three),
        .out_flags(out_flags), .parent_write(parent_write)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [31:0] clamp32(logic signed [127:0] v);
        logic [31:0] r;
        if (v > 128'sd2147483647)
            r = 32'h7FFF_FFFF;
        else if (v < -128'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [127:0] round_div(logic signed [127:0] m, logic [127:0] d);
        logic [127:0] mag;
        logic [127:0] q;
        mag = (m < 0) ? -m : m;
        q = (2 * mag + d) / (2 * d);
        if (q > Q_CAP)
            q = Q_CAP;
        return (m < 0) ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [127:0] halve_round(logic signed [127:0] d);
        logic signed [127:0] r;
        if (d >= 0)
            r = (d + 1) / 2;
        else
            r = -((-d + 1) / 2);
        return r;
    endfunction

    function automatic thws_pkg::out_item_t predict_haar_step(thws_pkg::in_item_t x);
        thws_pkg::out_item_t r;
        logic signed [127:0] v[4];
        logic [127:0] a[4];
        logic signed [127:0] m;
        logic signed [127:0] w0;
        logic [127:0] total;
        r.applied = 1'b0;
        r.flags = x.flags;
        r.parent_write = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            v[i] = $signed(x.value[i]);
            a[i] = {96'd0, x.area[i]};
            r.value[i] = x.value[i];
        end
        if (x.present && x.area[0] != 0)
        begin
            if (x.command == thws_pkg::CMD_ANALYSIS && x.flags != thws_pkg::FLAGS_ALL)
            begin
                m = 0;
                total = 0;
                for (int i = 0; i < 4; i++)
                begin
                    m = m + $signed(a[i]) * v[i];
                    total = total + a[i];
                end
                w0 = $signed(clamp32(round_div(m, total)));
                r.value[0] = w0[31:0];
                for (int i = 1; i < 4; i++)
                    r.value[i] = clamp32(halve_round(v[i] - w0));
                r.applied = 1'b1;
                r.flags = thws_pkg::FLAGS_ALL;
                r.parent_write = 1'b1;
            end
            else if (x.command == thws_pkg::CMD_SYNTHESIS && x.flags == thws_pkg::FLAGS_ALL)
            begin
                m = 0;
                for (int i = 1; i < 4; i++)
                    m = m + $signed(a[i]) * v[i];
                r.value[0] = clamp32(v[0] - round_div(2 * m, a[0]));
                for (int i = 1; i < 4; i++)
                    r.value[i] = clamp32(v[0] + 2 * v[i]);
                r.applied = 1'b1;
                r.flags = thws_pkg::FLAGS_NONE;
            end
        end
        return r;
    endfunction

    function automatic thws_pkg::in_item_t make_word(logic cmd, logic pres, logic [3:0] fl,
                                           logic [31:0] v0, logic [31:0] v1, logic [31:0] v2,
                                           logic [31:0] v3, logic [31:0] a0, logic [31:0] a1,
                                           logic [31:0] a2, logic [31:0] a3);
        thws_pkg::in_item_t w;
        w.command = cmd;
        w.present = pres;
        w.flags = fl;
        w.value[0] = v0; w.value[1] = v1; w.value[2] = v2; w.value[3] = v3;
        w.area[0] = a0; w.area[1] = a1; w.area[2] = a2; w.area[3] = a3;
        return w;
    endfunction

    task automatic add_row(thws_pkg::in_item_t w);
        row_t r;
        r.word = w;
        r.typed = 1'b0;
        r.result = '0;
        dir_rows.push_back(r);
    endtask

    task automatic add_skip_row(thws_pkg::in_item_t w);
        row_t r;
        r.word = w;
        r.typed = 1'b1;
        r.result.applied = 1'b0;
        r.result.value = w.value;
        r.result.flags = w.flags;
        r.result.parent_write = 1'b0;
        dir_rows.push_back(r);
    endtask

    task automatic add_typed_row(thws_pkg::in_item_t w, thws_pkg::out_item_t e);
        row_t r;
        r.word = w;
        r.typed = 1'b1;
        r.result = e;
        dir_rows.push_back(r);
    endtask

    function automatic logic [31:0] rand_value();
        logic [31:0] r;
        case ($urandom_range(0, 9))
            0: r = 32'h7FFF_FFFF;
            1: r = 32'h8000_0000;
            2, 3: r = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            default: r = $urandom;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] rand_area();
        logic [31:0] r;
        case ($urandom_range(0, 11))
            0: r = 32'd0;
            1: r = 32'hFFFF_FFFF;
            2, 3, 4: r = $urandom_range(1, 32'h0001_0000);
            default: r = $urandom;
        endcase
        return r;
    endfunction

    function automatic thws_pkg::in_item_t rand_word();
        thws_pkg::in_item_t w;
        int kind;
        kind = $urandom_range(0, 19);
        w.command = 1'($urandom_range(0, 1));
        w.present = (kind != 0);
        if (kind < 3)
            w.flags = 4'($urandom_range(0, 15));
        else if (w.command == thws_pkg::CMD_SYNTHESIS)
            w.flags = thws_pkg::FLAGS_ALL;
        else
            w.flags = 4'($urandom_range(0, 14));
        for (int i = 0; i < 4; i++)
        begin
            w.value[i] = rand_value();
            w.area[i] = rand_area();
        end
        if (kind != 1 && w.area[0] == 0)
            w.area[0] = $urandom_range(1, 32'hFFFF);
        return w;
    endfunction

    task automatic check_field(string nm, logic [31:0] e, logic [31:0] a);
        if (e !== a)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $realtime, nm, e, a);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        thws_pkg::out_item_t e;
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT)
        begin
            $display("triangle_haar_wavelet_step_core test failed");
            $finish;
        end
        if (rst_n && push && !full)
        begin
            if (pending_typed)
                expected_q.push_back(pending_result);
            else
                expected_q.push_back(predict_haar_step(cur));
        end
        if (rst_n && pop && !empty)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: result word with no expectation, actual out_zero %h",
                         $realtime, out_zero);
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                check_field("applied", 32'(e.applied), 32'(applied));
                check_field("out_zero", e.value[0], out_zero);
                check_field("out_one", e.value[1], out_one);
                check_field("out_two", e.value[2], out_two);
                check_field("out_three", e.value[3], out_three);
                check_field("out_flags", 32'(e.flags), 32'(out_flags));
                check_field("parent_write", 32'(e.parent_write), 32'(parent_write));
            end
        end
    end

    initial
    begin
        int hold_at;
        hold_at = 3000;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (cycles >= hold_at && hold_at > 0)
            begin
                pop <= 1'b0;
                hold_at = 0;
                repeat (400) @(posedge clk);
            end
            pop <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
            if ($urandom_range(0, 3) != 0)
            begin
                pop <= 1'b0;
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(20, 60)) @(posedge clk);
                else
                    repeat ($urandom_range(0, 2)) @(posedge clk);
            end
        end
    end

    initial
    begin
        thws_pkg::in_item_t w;
        thws_pkg::out_item_t e;
        int n_total;
        int gap;
        add_skip_row(make_word(thws_pkg::CMD_ANALYSIS, 1'b0, 4'h3, 32'h7FFF_FFFF,
                               32'h8000_0000, 32'h1, 32'hFFFF_FFFF, 32'h1, 32'h2, 32'h3,
                               32'h4));
        add_skip_row(make_word(thws_pkg::CMD_SYNTHESIS, 1'b0, thws_pkg::FLAGS_ALL, 32'h1234,
                               32'h5, 32'h6, 32'h7, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0));
        add_skip_row(make_word(thws_pkg::CMD_ANALYSIS, 1'b1, thws_pkg::FLAGS_ALL, 32'h10000,
                               32'h20000, 32'h30000, 32'h40000, 32'h5, 32'h5, 32'h5, 32'h5));
        add_skip_row(make_word(thws_pkg::CMD_SYNTHESIS, 1'b1, 4'h7, 32'h10000, 32'h20000,
                               32'h30000, 32'h40000, 32'h5, 32'h5, 32'h5, 32'h5));
        add_skip_row(make_word(thws_pkg::CMD_SYNTHESIS, 1'b1, 4'h0, 32'hFFFF_0000, 32'h1,
                               32'h2, 32'h3, 32'h1, 32'h1, 32'h1, 32'h1));
        add_skip_row(make_word(thws_pkg::CMD_ANALYSIS, 1'b1, 4'h0, 32'h10000, 32'h20000,
                               32'h30000, 32'h40000, 32'h0, 32'h5, 32'h5, 32'h5));
        add_skip_row(make_word(thws_pkg::CMD_SYNTHESIS, 1'b1, thws_pkg::FLAGS_ALL, 32'h10000,
                               32'h20000, 32'h30000, 32'h40000, 32'h0, 32'hFFFF_FFFF, 32'h5,
                               32'h5));
        e.applied = 1'b1;
        e.value = '0;
        e.flags = thws_pkg::FLAGS_NONE;
        e.parent_write = 1'b0;
        add_typed_row(make_word(thws_pkg::CMD_SYNTHESIS, 1'b1, thws_pkg::FLAGS_ALL, 32'h0,
                                32'h0, 32'h0, 32'h0, 32'h1, 32'h1, 32'h1, 32'h1), e);
        e.value[0] = 32'h5;
        e.flags = thws_pkg::FLAGS_ALL;
        e.parent_write = 1'b1;
        add_typed_row(make_word(thws_pkg::CMD_ANALYSIS, 1'b1, 4'h0, 32'h5, 32'h5, 32'h5, 32'h5,
                                32'h7, 32'h7, 32'h7, 32'h7), e);
        add_row(make_word(thws_pkg::CMD_ANALYSIS, 1'b1, 4'hE, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF));
        add_row(make_word(thws_pkg::CMD_ANALYSIS, 1'b1, 4'h1, 32'h8000_0000, 32'h7FFF_FFFF,
                          32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'hFFFF_FFFF,
                          32'h0, 32'hFFFF_FFFF));
        add_row(make_word(thws_pkg::CMD_SYNTHESIS, 1'b1, thws_pkg::FLAGS_ALL, 32'h8000_0000,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF));
        add_row(make_word(thws_pkg::CMD_SYNTHESIS, 1'b1, thws_pkg::FLAGS_ALL, 32'h7FFF_FFFF,
                          32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h1,
                          32'h1, 32'h1));
        add_row(make_word(thws_pkg::CMD_ANALYSIS, 1'b1, 4'h0, 32'h1, 32'h0, 32'h0, 32'h0,
                          32'h2, 32'h2, 32'h0, 32'h0));
        add_row(make_word(thws_pkg::CMD_ANALYSIS, 1'b1, 4'h0, 32'hFFFF_FFFF, 32'h0, 32'h0,
                          32'h0, 32'h2, 32'h2, 32'h0, 32'h0));
        add_row(make_word(thws_pkg::CMD_SYNTHESIS, 1'b1, thws_pkg::FLAGS_ALL, 32'h0, 32'h1,
                          32'h0, 32'h0, 32'h4, 32'h1, 32'h0, 32'h0));
        add_row(make_word(thws_pkg::CMD_SYNTHESIS, 1'b1, thws_pkg::FLAGS_ALL, 32'h0,
                          32'hFFFF_FFFF, 32'h0, 32'h0, 32'h4, 32'h1, 32'h0, 32'h0));

        n_total = dir_rows.size() + N_RANDOM;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int n = 0; n < n_total; n++)
        begin
            if (n == 1000)
            begin
                push <= 1'b0;
                @(posedge clk);
                while (expected_q.size() != 0)
                    @(posedge clk);
            end
            if (n < dir_rows.size())
            begin
                w = dir_rows[n].word;
                pending_typed <= dir_rows[n].typed;
                pending_result <= dir_rows[n].result;
            end
            else
            begin
                w = rand_word();
                pending_typed <= 1'b0;
            end
            cur <= w;
            push <= 1'b1;
            @(posedge clk);
            while (full)
                @(posedge clk);
            gap = $urandom_range(0, 99);
            if (gap >= 70)
            begin
                push <= 1'b0;
                if (gap >= 96)
                    repeat ($urandom_range(10, 40)) @(posedge clk);
                else
                    repeat ($urandom_range(1, 3)) @(posedge clk);
            end
        end
        push <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("triangle_haar_wavelet_step_core test passed");
        else
            $display("triangle_haar_wavelet_step_core test failed");
        $finish;
    end
endmodule
